/* rtl/fcm_pkg.sv */
package fcm_pkg;

   // Prediction table geometry
   localparam int INDEX_BITS  = 2;
   localparam int TABLE_SIZE  = 1 << INDEX_BITS;
   localparam int GROUP_SLOTS = 4;
   localparam int HELD_SLOTS  = GROUP_SLOTS - 1;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Residual size codes
   localparam logic [1:0] CODE_ZERO  = 2'd0;
   localparam logic [1:0] CODE_TWO   = 2'd1;
   localparam logic [1:0] CODE_THREE = 2'd2;
   localparam logic [1:0] CODE_FOUR  = 2'd3;

   // One unit of output work: optional header, optional group
   typedef struct packed {
      logic                                hdr;
      logic                                grp;
      logic                                last;
      logic [31:0]                         count;
      logic [GROUP_SLOTS-1:0][1:0]         codes;
      logic [GROUP_SLOTS-1:0][31:0]        res;
   } job_type;

   function automatic logic [1:0] size_code(input logic [31:0] r);
      logic [1:0] c;
      if (r == 32'd0) c = CODE_ZERO;
      else if (r[31:16] == 16'd0) c = CODE_TWO;
      else if (r[31:24] == 8'd0) c = CODE_THREE;
      else c = CODE_FOUR;
      return c;
   endfunction

   // Pick byte pos of a word, byte 0 is least significant
   function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = w[7:0];
         2'd1:    b = w[15:8];
         2'd2:    b = w[23:16];
         default: b = w[31:24];
      endcase
      return b;
   endfunction

endpackage

/* rtl/fcm_front.sv */
module fcm_front import fcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_float_bits,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic [31:0]                  word_count_ff;
   logic [TABLE_SIZE-1:0][31:0]  table_ff, table_in;
   logic [INDEX_BITS-1:0]        tindex_ff, tindex_in;
   logic [31:0]                  pred_ff, pred_in;
   logic [31:0]                  held_res_ff [HELD_SLOTS];
   logic [1:0]                   held_code_ff [HELD_SLOTS];
   logic [1:0]                   slot_ff;
   logic [31:0]                  seen_ff, seen_in;

   logic        accept;
   logic [31:0] resid;
   logic [1:0]  code;
   logic        last;
   logic        emit_grp;
   logic        hdr;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // Classify the word
   always_comb begin
      resid    = req_float_bits ^ pred_ff;
      code     = size_code(resid);
      seen_in  = seen_ff + 32'd1;
      last     = (seen_in == word_count_ff);
      hdr      = (seen_ff == 32'd0);
      emit_grp = (slot_ff == 2'd3) || last;
      table_in = table_ff;
      table_in[tindex_ff] = req_float_bits;
      tindex_in = req_float_bits[31 -: INDEX_BITS];
      pred_in   = table_in[tindex_in];
   end

   // Build the job: held slots, the current slot, padding after it
   always_comb begin
      q_job.hdr   = hdr;
      q_job.grp   = emit_grp;
      q_job.last  = last;
      q_job.count = word_count_ff;
      for (int k = 0; k < GROUP_SLOTS; k++) begin
         if (2'(k) < slot_ff) begin
            q_job.res[k]   = held_res_ff[k];
            q_job.codes[k] = held_code_ff[k];
         end else if (2'(k) == slot_ff) begin
            q_job.res[k]   = resid;
            q_job.codes[k] = code;
         end else begin
            q_job.res[k]   = 32'd0;
            q_job.codes[k] = CODE_TWO;
         end
      end
      q_push = accept && (hdr || emit_grp);
   end

   // Hold the length register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= 32'd1;
      end else if (csr_write_enable) begin
         word_count_ff <= csr_write_data;
      end
   end

   // Advance predictor and group state
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff  <= '0;
         tindex_ff <= '0;
         pred_ff   <= '0;
         slot_ff   <= '0;
         seen_ff   <= '0;
      end else if (accept) begin
         if (last) begin
            table_ff  <= '0;
            tindex_ff <= '0;
            pred_ff   <= '0;
            slot_ff   <= '0;
            seen_ff   <= '0;
         end else begin
            table_ff  <= table_in;
            tindex_ff <= tindex_in;
            pred_ff   <= pred_in;
            slot_ff   <= emit_grp ? 2'd0 : slot_ff + 2'd1;
            seen_ff   <= seen_in;
         end
      end
   end

   // Store the open group's residuals
   always_ff @(posedge clock) begin
      if (accept && !emit_grp) begin
         held_res_ff[slot_ff]  <= resid;
         held_code_ff[slot_ff] <= code;
      end
   end

endmodule

/* rtl/fcm_queue.sv */
module fcm_queue import fcm_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign head_job = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Move pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wrap_inc(wr_ff);
         if (do_pop) rd_ff <= wrap_inc(rd_ff);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

/* rtl/fcm_back.sv */
module fcm_back import fcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_done
);

   typedef enum logic [1:0] {PH_START, PH_HDR, PH_CODE, PH_DATA} phase_type;

   typedef struct packed {
      logic       found;
      logic [1:0] idx;
   } pick_type;

   phase_type  phase_ff, cur_phase, nxt_phase;
   logic [1:0] cnt_ff, cur_cnt, nxt_cnt;
   logic [1:0] slot_ff, nxt_slot;
   logic       last_byte;
   logic       take;
   pick_type   pick;

   // Find the first slot at or after start that carries bytes
   function automatic pick_type first_nz(input logic [GROUP_SLOTS-1:0][1:0] c,
                                         input logic [2:0] start);
      pick_type p;
      p = '0;
      for (int k = 0; k < GROUP_SLOTS; k++) begin
         if (!p.found && 3'(k) >= start && c[k] != CODE_ZERO) begin
            p.found = 1'b1;
            p.idx   = 2'(k);
         end
      end
      return p;
   endfunction

   // Pick the current byte and the step after it
   always_comb begin
      if (phase_ff == PH_START) begin
         cur_phase = q_job.hdr ? PH_HDR : PH_CODE;
         cur_cnt   = 2'd3;
      end else begin
         cur_phase = phase_ff;
         cur_cnt   = cnt_ff;
      end
      nxt_phase    = cur_phase;
      nxt_cnt      = cur_cnt;
      nxt_slot     = slot_ff;
      last_byte    = 1'b0;
      rsp_out_byte = 8'd0;
      pick         = '0;
      case (cur_phase)
         PH_HDR: begin
            rsp_out_byte = byte_of(q_job.count, cur_cnt);
            if (cur_cnt == 2'd0) begin
               last_byte = !q_job.grp;
               nxt_phase = PH_CODE;
            end else begin
               nxt_cnt = cur_cnt - 2'd1;
            end
         end
         PH_CODE: begin
            rsp_out_byte = {q_job.codes[3], q_job.codes[2], q_job.codes[1], q_job.codes[0]};
            pick = first_nz(q_job.codes, 3'd0);
            last_byte = !pick.found;
            nxt_phase = PH_DATA;
            nxt_slot  = pick.idx;
            nxt_cnt   = q_job.codes[pick.idx];
         end
         PH_DATA: begin
            rsp_out_byte = byte_of(q_job.res[slot_ff], cur_cnt);
            if (cur_cnt != 2'd0) begin
               nxt_cnt = cur_cnt - 2'd1;
            end else begin
               pick = first_nz(q_job.codes, {1'b0, slot_ff} + 3'd1);
               last_byte = !pick.found;
               nxt_slot  = pick.idx;
               nxt_cnt   = q_job.codes[pick.idx];
            end
         end
         default: begin
            last_byte = 1'b1;
         end
      endcase
   end

   assign take            = rsp_pop && q_valid;
   assign q_pop           = take && last_byte;
   assign rsp_empty       = !q_valid;
   assign rsp_run_last    = last_byte;
   assign rsp_stream_done = last_byte && q_job.last;

   // Advance the byte sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         cnt_ff   <= '0;
         slot_ff  <= '0;
      end else if (take) begin
         if (last_byte) begin
            phase_ff <= PH_START;
         end else begin
            phase_ff <= nxt_phase;
            cnt_ff   <= nxt_cnt;
            slot_ff  <= nxt_slot;
         end
      end
   end

endmodule

/* rtl/fcm_float_stream_compressor_unit.sv */
// Float stream compressor: each 32-bit word is XORed with a context prediction
// and the residuals are packed four to a group (code byte, then significant
// bytes), with a 4-byte word count header at the start of each stream. The
// front accepts one word per cycle while the job queue has room; it pushes a
// job only at a stream start or a finished group. The back serializes one byte
// per cycle from the head job while the output is popped, so sustained
// throughput is set by the output byte rate: a group costs 1 to 17 bytes for
// four words, plus 4 for a header.
module fcm_float_stream_compressor_unit import fcm_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_float_bits,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_stream_done,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic    q_full, q_push, q_valid, q_pop;
   job_type push_job, head_job;

   fcm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_float_bits   (req_float_bits),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   fcm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_job (head_job)
   );

   fcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

/* rtl/fcm_checker.sv */
module fcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_run_last,
   input logic        rsp_stream_done
);

   // Stream end always closes a run's output
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_stream_done) |-> rsp_run_last)
      else $error("stream_done without run_last");

   // Reset drains the output side
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("output not empty after reset");

   // Reset leaves room for input
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // A waiting word holds until taken
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)
                                    && $stable(rsp_run_last) && $stable(rsp_stream_done)))
      else $error("waiting output word changed");

   // No output appears without an accepted input
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !(req_push && !req_full)) |=> rsp_empty)
      else $error("output appeared without input");

endmodule

bind fcm_float_stream_compressor_unit fcm_checker u_checker (.*);
